// File: hdl/mqfb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the message queue with front and back post.
// No dependencies; every other file but mqfb_ram imports this package.
package mqfb_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int MSG_WIDTH_DEF = 32;

    localparam int OP_W   = 2;
    localparam int MSG_W  = 32;
    localparam int STAT_W = 2;
    localparam int CNT_W  = 5;
    localparam int QS_W   = 5;

    localparam logic [QS_W-1:0] QS_RESET = QS_W'(16);

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam int REG_IDX_W = APB_AW - 2;
    localparam logic [REG_IDX_W-1:0] REG_QUEUE_SIZE = REG_IDX_W'(0);

    localparam int CMDQ_DEPTH = 2;

    typedef enum logic [OP_W-1:0] {
        OP_POST_BACK  = 2'd0,
        OP_POST_FRONT = 2'd1,
        OP_TAKE       = 2'd2,
        OP_FLUSH      = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    // Control part of one command passed from the front to the back
    typedef struct packed {
        logic             wr;
        logic             rd;
        t_status          status;
        logic [CNT_W-1:0] count;
    } t_cmd_ctl;

endpackage

// File: hdl/mqfb_req_if.sv
`timescale 1ns / 1ps
// Request channel: valid/ready handshake carrying op and message word.
// Depends on mqfb_pkg.
interface mqfb_req_if import mqfb_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [MSG_W-1:0] msg;

    modport source (output valid, output op, output msg, input ready);
    modport sink   (input valid, input op, input msg, output ready);
endinterface

// File: hdl/mqfb_rsp_if.sv
`timescale 1ns / 1ps
// Response channel: valid/ready handshake carrying status, message and count.
// Depends on mqfb_pkg.
interface mqfb_rsp_if import mqfb_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [MSG_W-1:0]  msg_out;
    logic [CNT_W-1:0]  entry_count;

    modport source (output valid, output status, output msg_out, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input msg_out, input entry_count,
                    output ready);
endinterface

// File: hdl/mqfb_ram.sv
`timescale 1ns / 1ps
// Generic single-port RAM with registered read data that holds between reads.
// No dependencies.
module mqfb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/mqfb_cmd_fifo.sv
`timescale 1ns / 1ps
// Short command queue between the front and the back.
// Depends on mqfb_pkg for its depth.
module mqfb_cmd_fifo import mqfb_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = $clog2(CMDQ_DEPTH);
    localparam int FILL_W = $clog2(CMDQ_DEPTH + 1);

    logic [WIDTH-1:0]  r_mem [CMDQ_DEPTH];
    logic [PTR_W-1:0]  r_wp, n_wp;
    logic [PTR_W-1:0]  r_rp, n_rp;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic              push_ok;
    logic              pop_ok;

    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && o_valid;

    always_comb begin
        n_wp = r_wp;
        n_rp = r_rp;
        n_fill = r_fill;
        if (push_ok) begin
            n_wp = (32'(r_wp) == CMDQ_DEPTH - 1) ? '0 : r_wp + PTR_W'(1);
        end
        if (pop_ok) begin
            n_rp = (32'(r_rp) == CMDQ_DEPTH - 1) ? '0 : r_rp + PTR_W'(1);
        end
        if (push_ok && !pop_ok) begin
            n_fill = r_fill + FILL_W'(1);
        end else if (pop_ok && !push_ok) begin
            n_fill = r_fill - FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_fill <= '0;
        end else begin
            r_wp <= n_wp;
            r_rp <= n_rp;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_full  = (32'(r_fill) == CMDQ_DEPTH);
    assign o_valid = (r_fill != '0);
    assign o_data  = r_mem[r_rp];

endmodule

// File: hdl/mqfb_front.sv
`timescale 1ns / 1ps
// Front: accepts requests, tracks indices and count, classifies each request
// and emits a store command. Depends on mqfb_pkg and mqfb_req_if.
module mqfb_front import mqfb_pkg::*; #(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int MSG_WIDTH = MSG_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    mqfb_req_if.sink                 i_req,
    input  logic [CNT_W-1:0]         i_size,
    input  logic                     i_clr,
    input  logic                     i_cmd_full,
    output logic                     o_cmd_push,
    output t_cmd_ctl                 o_cmd_ctl,
    output logic [$clog2(DEPTH)-1:0] o_cmd_addr,
    output logic [MSG_WIDTH-1:0]     o_cmd_data
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int SW = ((IDX_W > CNT_W) ? IDX_W : CNT_W) + 1;

    logic [IDX_W-1:0] r_wr, n_wr;
    logic [IDX_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             accept;
    logic             full;
    logic             empty;
    logic [IDX_W-1:0] wr_inc;
    logic [IDX_W-1:0] rd_inc;
    logic [IDX_W-1:0] rd_dec;
    t_op              op;

    assign i_req.ready = !i_cmd_full;
    assign accept = i_req.valid && !i_cmd_full;
    assign op = t_op'(i_req.op);

    assign full  = (r_cnt >= i_size);
    assign empty = (r_cnt == '0);

    // Wrap at the used size, not at the store depth
    assign wr_inc = (SW'(r_wr) + SW'(1) == SW'(i_size)) ? '0 : r_wr + IDX_W'(1);
    assign rd_inc = (SW'(r_rd) + SW'(1) == SW'(i_size)) ? '0 : r_rd + IDX_W'(1);
    assign rd_dec = (r_rd == '0) ? IDX_W'(SW'(i_size) - SW'(1)) : r_rd - IDX_W'(1);

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        n_cnt = r_cnt;
        o_cmd_ctl = '0;
        o_cmd_ctl.status = ST_OK;
        o_cmd_addr = r_wr;
        unique case (op)
            OP_POST_BACK: begin
                if (full) begin
                    o_cmd_ctl.status = ST_FULL;
                end else begin
                    o_cmd_ctl.wr = 1'b1;
                    o_cmd_addr = r_wr;
                    n_wr = wr_inc;
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            OP_POST_FRONT: begin
                if (full) begin
                    o_cmd_ctl.status = ST_FULL;
                end else begin
                    o_cmd_ctl.wr = 1'b1;
                    o_cmd_addr = rd_dec;
                    n_rd = rd_dec;
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            OP_TAKE: begin
                if (empty) begin
                    o_cmd_ctl.status = ST_EMPTY;
                end else begin
                    o_cmd_ctl.rd = 1'b1;
                    o_cmd_addr = r_rd;
                    n_rd = rd_inc;
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            OP_FLUSH: begin
                n_wr = '0;
                n_rd = '0;
                n_cnt = '0;
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
        o_cmd_ctl.count = n_cnt;
    end

    assign o_cmd_push = accept;
    assign o_cmd_data = MSG_WIDTH'(i_req.msg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else if (accept) begin
            r_wr <= n_wr;
            r_rd <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

// File: hdl/mqfb_back.sv
`timescale 1ns / 1ps
// Back: pops store commands, runs them on the message RAM and registers the
// response beat. Depends on mqfb_pkg, mqfb_rsp_if and mqfb_ram.
module mqfb_back import mqfb_pkg::*; #(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int MSG_WIDTH = MSG_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cmd_valid,
    input  t_cmd_ctl                 i_cmd_ctl,
    input  logic [$clog2(DEPTH)-1:0] i_cmd_addr,
    input  logic [MSG_WIDTH-1:0]     i_cmd_data,
    output logic                     o_cmd_pop,
    mqfb_rsp_if.source               o_rsp
);

    logic             r_p1_valid;
    t_cmd_ctl         r_p1_ctl;
    logic             r_out_valid;
    t_status          r_out_status;
    logic [MSG_W-1:0] r_out_msg;
    logic [CNT_W-1:0] r_out_cnt;
    logic             p1_move;
    logic             issue;
    logic [MSG_WIDTH-1:0] rdata;

    // Read data holds in the RAM while the issue stage is stalled
    assign p1_move = r_p1_valid && (!r_out_valid || o_rsp.ready);
    assign issue = i_cmd_valid && (!r_p1_valid || p1_move);
    assign o_cmd_pop = issue;

    mqfb_ram #(
        .WIDTH (MSG_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (issue && i_cmd_ctl.wr),
        .i_re    (issue && i_cmd_ctl.rd),
        .i_addr  (i_cmd_addr),
        .i_wdata (i_cmd_data),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (issue) begin
                r_p1_valid <= 1'b1;
            end else if (p1_move) begin
                r_p1_valid <= 1'b0;
            end
            if (p1_move) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_p1_ctl <= i_cmd_ctl;
        end
        if (p1_move) begin
            r_out_status <= r_p1_ctl.status;
            r_out_cnt <= r_p1_ctl.count;
            r_out_msg <= r_p1_ctl.rd ? MSG_W'(rdata) : '0;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.msg_out     = r_out_msg;
    assign o_rsp.entry_count = r_out_cnt;

endmodule

// File: hdl/message_queue_front_back_post_top.sv
`timescale 1ns / 1ps
// Circular message queue with post at back, post at front, take and flush. One request
// beat gives one response beat: the command queue, the issue register and the output
// register lie between the accepted request and the response valid. The block sustains
// one item per cycle while o_rsp.ready is high: each item makes at most one access to the
// single-port message RAM, which sets that rate. The front keeps indices and count and
// classifies each request; a two-entry command queue decouples it from the back, which runs
// the RAM access and holds the response in an output register. Writing queue_size (APB
// offset 0) empties the queue; a size of 0 acts as 1 and a size above DEPTH acts as DEPTH.
// No clearing pass at reset.
module message_queue_front_back_post_top import mqfb_pkg::*; #(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int MSG_WIDTH = MSG_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    mqfb_req_if.sink          i_req,
    mqfb_rsp_if.source        o_rsp,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CMD_W = $bits(t_cmd_ctl) + IDX_W + MSG_WIDTH;

    function automatic logic [CNT_W-1:0] f_used_size(input logic [QS_W-1:0] qs);
        logic [CNT_W-1:0] size;
        if (qs == '0) begin
            size = CNT_W'(1);
        end else if (32'(qs) > DEPTH) begin
            size = CNT_W'(DEPTH);
        end else begin
            size = CNT_W'(qs);
        end
        return size;
    endfunction

    logic [QS_W-1:0]  r_queue_size;
    logic [CNT_W-1:0] r_size;
    logic             reg_sel;
    logic             cfg_wr;

    logic             cmd_push;
    logic             cmd_full;
    t_cmd_ctl         front_ctl;
    logic [IDX_W-1:0] front_addr;
    logic [MSG_WIDTH-1:0] front_data;
    logic             cmd_valid;
    logic             cmd_pop;
    logic [CMD_W-1:0] cmd_word;
    t_cmd_ctl         back_ctl;
    logic [IDX_W-1:0] back_addr;
    logic [MSG_WIDTH-1:0] back_data;

    assign reg_sel = (paddr[APB_AW-1:2] == REG_QUEUE_SIZE);
    assign cfg_wr = psel && penable && pwrite && reg_sel;
    assign pready = 1'b1;
    assign prdata = reg_sel ? APB_DW'(r_queue_size) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_size <= QS_RESET;
            r_size <= f_used_size(QS_RESET);
        end else if (cfg_wr) begin
            r_queue_size <= pwdata[QS_W-1:0];
            r_size <= f_used_size(pwdata[QS_W-1:0]);
        end
    end

    mqfb_front #(
        .DEPTH     (DEPTH),
        .MSG_WIDTH (MSG_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_size     (r_size),
        .i_clr      (cfg_wr),
        .i_cmd_full (cmd_full),
        .o_cmd_push (cmd_push),
        .o_cmd_ctl  (front_ctl),
        .o_cmd_addr (front_addr),
        .o_cmd_data (front_data)
    );

    mqfb_cmd_fifo #(
        .WIDTH (CMD_W)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  ({front_ctl, front_addr, front_data}),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_data  (cmd_word)
    );

    assign {back_ctl, back_addr, back_data} = cmd_word;

    mqfb_back #(
        .DEPTH     (DEPTH),
        .MSG_WIDTH (MSG_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd_ctl   (back_ctl),
        .i_cmd_addr  (back_addr),
        .i_cmd_data  (back_data),
        .o_cmd_pop   (cmd_pop),
        .o_rsp       (o_rsp)
    );

`ifndef NO_ASSERTIONS
    a_count_in_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.entry_count <= r_size))
        else $error("entry count above used size");

    a_full_at_size: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_FULL) |-> (o_rsp.entry_count == r_size))
        else $error("full status while below used size");

    a_empty_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == ST_EMPTY)
            |-> (o_rsp.entry_count == '0 && o_rsp.msg_out == '0))
        else $error("empty status with messages held or data returned");
`endif

endmodule
